// File: sv/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg
// Types, character codes and classifiers shared by the line tokenizer.
// ----------------------------------------------------------------------------
package slt_pkg;

	typedef enum logic [2:0] {
		ST_START   = 3'd0,
		ST_WORD    = 3'd1,
		ST_QUOTE   = 3'd2,
		ST_UNQUOTE = 3'd3,
		ST_SPECIAL = 3'd4
	} lex_state_t;

	typedef enum logic [1:0] {
		K_BYTE  = 2'd0,
		K_END   = 2'd1,
		K_DONE  = 2'd2,
		K_ERROR = 2'd3
	} kind_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_PIPE  = 8'h7C;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] token_byte;
		logic       last;
	} result_t;

	// up to two results per input beat; r0 goes out first
	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} lex_out_t;

	function automatic result_t mk_result(kind_t kind, logic [7:0] b);
		result_t r;
		r.kind       = kind;
		r.token_byte = (kind == K_BYTE) ? b : 8'h00;
		r.last       = 1'b0;
		return r;
	endfunction

	function automatic logic is_line_end(logic [7:0] c);
		return (c == CH_NL) || (c == CH_NUL);
	endfunction

	function automatic logic is_blank(logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) ||
			(c == CH_FF) || (c == CH_CR);
	endfunction

	function automatic logic is_special(logic [7:0] c);
		return (c == CH_PIPE) || (c == CH_LT) || (c == CH_GT);
	endfunction

endpackage

// File: sv/slt_lexer.sv
// ----------------------------------------------------------------------------
// slt_lexer
// Five-state lexer: lex state register plus next-state and result decode.
// ----------------------------------------------------------------------------
module slt_lexer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        ch,
	output slt_pkg::lex_out_t res
);
	import slt_pkg::*;

	lex_state_t state_q;
	lex_state_t state_d;
	result_t    r0;
	result_t    r1;
	logic [1:0] n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_START;
		end else if (step) begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		r0      = mk_result(K_BYTE, 8'h00);
		r1      = mk_result(K_BYTE, 8'h00);
		n       = 2'd0;
		unique case (state_q)
			ST_WORD, ST_UNQUOTE: begin
				if (is_line_end(ch)) begin
					r0 = mk_result(K_END, 8'h00);
					r1 = mk_result(K_DONE, 8'h00);
					n = 2'd2;
					state_d = ST_START;
				end else if (is_blank(ch)) begin
					r0 = mk_result(K_END, 8'h00);
					n = 2'd1;
					state_d = ST_START;
				end else if (is_special(ch)) begin
					r0 = mk_result(K_END, 8'h00);
					r1 = mk_result(K_BYTE, ch);
					n = 2'd2;
					state_d = ST_SPECIAL;
				end else if (ch == CH_QUOTE) begin
					state_d = ST_QUOTE;
				end else begin
					r0 = mk_result(K_BYTE, ch);
					n = 2'd1;
					state_d = ST_WORD;
				end
			end
			ST_QUOTE: begin
				if (is_line_end(ch)) begin
					r0 = mk_result(K_ERROR, 8'h00);
					n = 2'd1;
					state_d = ST_START;
				end else if (ch == CH_QUOTE) begin
					state_d = ST_UNQUOTE;
				end else begin
					r0 = mk_result(K_BYTE, ch);
					n = 2'd1;
				end
			end
			ST_SPECIAL: begin
				if (is_line_end(ch)) begin
					r0 = mk_result(K_END, 8'h00);
					r1 = mk_result(K_DONE, 8'h00);
					n = 2'd2;
					state_d = ST_START;
				end else if (is_blank(ch)) begin
					r0 = mk_result(K_END, 8'h00);
					n = 2'd1;
					state_d = ST_START;
				end else if (is_special(ch)) begin
					r0 = mk_result(K_BYTE, ch);
					n = 2'd1;
				end else if (ch == CH_QUOTE) begin
					r0 = mk_result(K_END, 8'h00);
					n = 2'd1;
					state_d = ST_QUOTE;
				end else begin
					r0 = mk_result(K_END, 8'h00);
					r1 = mk_result(K_BYTE, ch);
					n = 2'd2;
					state_d = ST_WORD;
				end
			end
			default: begin
				if (is_line_end(ch)) begin
					r0 = mk_result(K_DONE, 8'h00);
					n = 2'd1;
					state_d = ST_START;
				end else if (is_blank(ch)) begin
					state_d = ST_START;
				end else if (ch == CH_QUOTE) begin
					state_d = ST_QUOTE;
				end else if (is_special(ch)) begin
					r0 = mk_result(K_BYTE, ch);
					n = 2'd1;
					state_d = ST_SPECIAL;
				end else begin
					r0 = mk_result(K_BYTE, ch);
					n = 2'd1;
					state_d = ST_WORD;
				end
			end
		endcase
		if (n == 2'd1) begin
			r0.last = 1'b1;
		end
		if (n == 2'd2) begin
			r1.last = 1'b1;
		end
		res.n  = n;
		res.r0 = r0;
		res.r1 = r1;
	end

`ifndef NO_ASSERTIONS
	a_pair_starts_with_end: assert property (@(posedge clk) disable iff (!arst_n)
		res.n == 2'd2 |-> res.r0.kind == K_END)
		else $error("two results without a leading end of token");
	a_line_end_to_start: assert property (@(posedge clk) disable iff (!arst_n)
		step && is_line_end(ch) |=> state_q == ST_START)
		else $error("line end did not return lexer to start");
	a_error_only_in_quote: assert property (@(posedge clk) disable iff (!arst_n)
		res.n != 2'd0 && res.r0.kind == K_ERROR |-> state_q == ST_QUOTE)
		else $error("quote error outside quoted text");
`endif

endmodule

// File: sv/slt_out_buf.sv
// ----------------------------------------------------------------------------
// slt_out_buf
// Two-slot result register; sends the results of one beat one per cycle while m_tready is high.
// ----------------------------------------------------------------------------
module slt_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  slt_pkg::lex_out_t res,
	output logic              free,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,
	output logic [1:0]        m_tuser,
	output logic              m_tlast
);
	import slt_pkg::*;

	result_t    slot0_q;
	result_t    slot1_q;
	logic [1:0] rem_q;
	logic       pop;

	assign pop      = (rem_q != 2'd0) && m_tready;
	assign free     = (rem_q == 2'd0) || ((rem_q == 2'd1) && m_tready);
	assign m_tvalid = (rem_q != 2'd0);
	assign m_tdata  = slot0_q.token_byte;
	assign m_tuser  = slot0_q.kind;
	assign m_tlast  = slot0_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 2'd0;
		end else if (load && res.n != 2'd0) begin
			rem_q <= res.n;
		end else if (pop) begin
			rem_q <= rem_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && res.n != 2'd0) begin
			slot0_q <= res.r0;
			slot1_q <= res.r1;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

endmodule

// File: sv/shell_line_tokenizer.sv
// ----------------------------------------------------------------------------
// shell_line_tokenizer
// Streaming shell command-line lexer: bytes in, token bytes and markers out.
// ----------------------------------------------------------------------------
// Slave side: one command-line byte per beat on s_tdata. 0x0A or 0x00 ends
// the line. Master side: one result per beat; m_tuser is the kind (token
// byte, end of token, line done, unmatched quote), m_tdata the token byte
// (zero for markers), m_tlast marks the last result of one input byte.
// An input beat is registered in the input stage, decoded there by the
// lexer, and its results are loaded into the result register and sent out.
// Throughput: one input byte per cycle while each byte gives one result
// at most and m_tready is high; a byte giving two results (token boundary)
// holds the input until its first result has drained from the register.
// Bytes that give no result (whitespace at start, most quotes) load nothing.
// Reset clears the lexer to start and empties both stages.
// When the receiver stalls, the result register holds and the input stage
// fills; s_tready drops once both are occupied.
// ----------------------------------------------------------------------------
module shell_line_tokenizer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] ch
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] token_byte
	output logic [1:0] m_tuser,   // [1:0] kind
	output logic       m_tlast
);
	import slt_pkg::*;

	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       free;
	logic       advance;
	lex_out_t   res;

	assign advance  = valid_s1 && free;
	assign s_tready = !valid_s1 || free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ch_s1 <= s_tdata;
		end
	end

	slt_lexer u_lexer (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.ch     (ch_s1),
		.res    (res)
	);

	slt_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.res      (res),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
